@@ rtl/core/yrgb_pkg.sv @@
package yrgb_pkg;

	localparam int PIX_W      = 8;
	localparam int TERM_W     = 12;
	localparam int ADDR_W     = 22;
	localparam int SIZE_W     = 12;
	localparam int RGB_W      = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 2;

	localparam int DEF_MAX_WIDTH   = 2048;
	localparam int DEF_MAX_HEIGHT  = 2048;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd320;
	localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd240;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ROTATE_MODE  = 2'd2
	} cfg_reg_t;

	// One classified quad: samples, chroma terms and its address plan.
	typedef struct packed {
		logic [3:0][PIX_W-1:0]    luma;
		logic signed [TERM_W-1:0] cc;
		logic signed [TERM_W-1:0] cg;
		logic signed [TERM_W-1:0] ca;
		logic [ADDR_W-1:0]        addr_a;
		logic [ADDR_W-1:0]        addr_b;
		logic [SIZE_W-1:0]        step;
		logic                     frame_end;
	} quad_entry_t;

endpackage

@@ rtl/core/yrgb_front.sv @@
module yrgb_front #(
	parameter int MAX_WIDTH  = yrgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yrgb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [yrgb_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [yrgb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [yrgb_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 q_ready,
	output logic                                 push,
	output yrgb_pkg::quad_entry_t                push_entry
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW = yrgb_pkg::ADDR_W;
	localparam int SW = yrgb_pkg::SIZE_W;
	localparam int TW = yrgb_pkg::TERM_W;
	localparam int PW = yrgb_pkg::PIX_W;
	localparam int MAX_W_EVEN = (MAX_WIDTH / 2) * 2;
	localparam int MAX_H_EVEN = (MAX_HEIGHT / 2) * 2;

	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;
	logic          rotate_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;
	logic          last_col;
	logic          last_row;
	logic          accept;

	logic signed [TW-1:0] u_x;
	logic signed [TW-1:0] v_x;
	logic signed [TW-1:0] cc_sum;
	logic signed [TW-1:0] ca_sum;

	logic [AW-1:0]   mul_a;
	logic [AW-1:0]   mul_b;
	logic [2*AW-1:0] product;
	logic [AW-1:0]   quad_addr;

	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] raw, input int maxv);
		logic [SW-1:0] v;
		v = {raw[SW-1:1], 1'b0};
		if (v < SW'(2))
			v = SW'(2);
		if (32'(v) > 32'(maxv))
			v = SW'(maxv);
		return v;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= yrgb_pkg::RESET_WIDTH;
			height_q <= yrgb_pkg::RESET_HEIGHT;
			rotate_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				yrgb_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				yrgb_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				yrgb_pkg::REG_ROTATE_MODE:  rotate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_size(width_q, MAX_W_EVEN);
	assign h_eff = eff_size(height_q, MAX_H_EVEN);

	assign last_col = (32'(col_q) + 32'd2) >= 32'(w_eff);
	assign last_row = (32'(row_q) + 32'd2) >= 32'(h_eff);

	assign s_tready = q_ready;
	assign accept   = s_tvalid && q_ready;
	assign push     = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(2);
			end else begin
				col_q <= col_q + CW'(2);
			end
		end
	end

	// Chroma terms; all shifts are arithmetic.
	always_comb begin
		u_x    = TW'($signed(s_tdata[4*PW +: PW]));
		v_x    = TW'($signed(s_tdata[5*PW +: PW]));
		cc_sum = (u_x <<< 1) + (u_x >>> 5) - TW'(64);
		ca_sum = v_x + (v_x >>> 3) - TW'(36);
	end

	// Rotated frames use x*H + y, normal frames (H-1-y)*W + x; both wrap at the address width.
	always_comb begin
		if (rotate_q) begin
			mul_a = AW'(col_q);
			mul_b = AW'(h_eff);
		end else begin
			mul_a = AW'(h_eff) - AW'(1) - AW'(row_q);
			mul_b = AW'(w_eff);
		end
		product   = mul_a * mul_b;
		quad_addr = product[AW-1:0] + (rotate_q ? AW'(row_q) : AW'(col_q));
	end

	always_comb begin
		push_entry.luma[0]   = s_tdata[0*PW +: PW];
		push_entry.luma[1]   = s_tdata[1*PW +: PW];
		push_entry.luma[2]   = s_tdata[2*PW +: PW];
		push_entry.luma[3]   = s_tdata[3*PW +: PW];
		push_entry.cc        = cc_sum >>> 1;
		push_entry.cg        = TW'(31) - (u_x >>> 2) - (u_x >>> 3) - (v_x >>> 1) - (v_x >>> 4);
		push_entry.ca        = ca_sum >>> 1;
		push_entry.addr_a    = quad_addr;
		push_entry.addr_b    = rotate_q ? quad_addr + AW'(1) : quad_addr - AW'(w_eff);
		push_entry.step      = rotate_q ? h_eff : SW'(1);
		push_entry.frame_end = last_col && last_row;
	end

endmodule

@@ rtl/core/yrgb_queue.sv @@
module yrgb_queue #(
	parameter int DEPTH = yrgb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  yrgb_pkg::quad_entry_t push_entry,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  head_valid,
	output yrgb_pkg::quad_entry_t head_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	yrgb_pkg::quad_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign push_ready = count_q != NW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_ready || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - NW'(1))
		else $error("queue count did not follow a read");

endmodule

@@ rtl/core/yrgb_back.sv @@
module yrgb_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  yrgb_pkg::quad_entry_t               head_entry,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [yrgb_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);

	localparam int AW = yrgb_pkg::ADDR_W;
	localparam int TW = yrgb_pkg::TERM_W;
	localparam int PAD_W = yrgb_pkg::OUT_DATA_W - AW - yrgb_pkg::RGB_W;

	yrgb_pkg::quad_entry_t cur_q;
	logic                  cur_valid_q;
	logic [1:0]            pix_q;
	logic                  m_tvalid_q;
	logic [yrgb_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;

	logic                          out_load;
	logic                          cur_done;
	logic [AW-1:0]                 pix_addr;
	logic [yrgb_pkg::RGB_W-1:0]    pix_rgb;

	function automatic logic [5:0] clamp_term(input logic signed [TW-1:0] x,
			input logic [5:0] hi);
		logic [5:0] r;
		if (x < 0)
			r = '0;
		else if (x > $signed(TW'(hi)))
			r = hi;
		else
			r = x[5:0];
		return r;
	endfunction

	function automatic logic [yrgb_pkg::RGB_W-1:0] pack_rgb(
			input logic [yrgb_pkg::PIX_W-1:0] l, input logic signed [TW-1:0] cc,
			input logic signed [TW-1:0] cg, input logic signed [TW-1:0] ca);
		logic signed [TW-1:0] lx;
		logic signed [TW-1:0] hl;
		logic [5:0] b;
		logic [5:0] g;
		logic [5:0] r;
		lx = TW'($signed(l));
		hl = lx >>> 1;
		b  = clamp_term(hl + cc, 6'd31);
		g  = clamp_term(lx + cg, 6'd63);
		r  = clamp_term(hl + ca, 6'd31);
		return {r[4:0], g, b[4:0]};
	endfunction

	assign out_load = cur_valid_q && (!m_tvalid_q || m_tready);
	assign cur_done = out_load && (pix_q == 2'd3);
	assign pop      = head_valid && (!cur_valid_q || cur_done);

	// Pixel order: top-left, top-right, bottom-left, bottom-right.
	assign pix_addr = (pix_q[1] ? cur_q.addr_b : cur_q.addr_a) +
		(pix_q[0] ? AW'(cur_q.step) : AW'(0));
	assign pix_rgb  = pack_rgb(cur_q.luma[pix_q], cur_q.cc, cur_q.cg, cur_q.ca);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pix_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pix_q       <= '0;
			end else begin
				if (out_load)
					pix_q <= pix_q + 2'd1;
				if (cur_done)
					cur_valid_q <= 1'b0;
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head_entry;
		if (out_load) begin
			m_tdata_q <= {PAD_W'(0), pix_rgb, pix_addr};
			m_tuser_q <= pix_q == 2'd3;
			m_tlast_q <= (pix_q == 2'd3) && cur_q.frame_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_frame_end_on_quad_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("frame end flagged on a pixel that does not close its quad");

	a_fourth_pixel_marked: assert property (@(posedge clk) disable iff (!arst_n)
		cur_done |=> (m_tvalid && m_tuser))
		else $error("fourth pixel of a quad left unmarked");

	a_pop_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cur_valid_q) |-> cur_done)
		else $error("new quad loaded over one still in progress");

endmodule

@@ rtl/core/yuv420_to_rgb565_flip_rotate_top.sv @@
// YUV 4:2:0 to RGB565 converter with bottom-up flip or transpose.
// The s_ channel takes one 2x2 luma quad with its U and V samples per request,
// quads in raster order. The m_ channel gives four pixels per quad (top-left,
// top-right, bottom-left, bottom-right), each with its output word address.
// The cfg_ channel writes frame_width (0), frame_height (1) and rotate_mode (2);
// it is always ready; the user must write it only while no quad is in flight,
// which the block does not enforce. A quad passes the queue, then the
// current-quad register, then the single pixel output stage, which serializes
// each quad at one pixel per cycle while m_tready is high and quads wait.
// A four-entry queue sits between the quad front end and the pixel back end,
// so while m_tready is low the back end holds its output register and the
// front keeps taking quads until the queue is full; then s_tready drops.
// Reset clears the column and row counters, empties the queue and restores
// a 320x240 normal-mode frame.
module yuv420_to_rgb565_flip_rotate_top #(
	parameter int MAX_WIDTH   = yrgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = yrgb_pkg::DEF_MAX_HEIGHT,
	parameter int QUEUE_DEPTH = yrgb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
	// chroma_u, chroma_v
	input  logic [yrgb_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_address, pixel_rgb, zero padding
	output logic [yrgb_pkg::OUT_DATA_W-1:0]    m_tdata,
	// last_of_quad
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [yrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [yrgb_pkg::SIZE_W-1:0]        cfg_data
);

	logic                  push;
	logic                  push_ready;
	yrgb_pkg::quad_entry_t push_entry;
	logic                  pop;
	logic                  head_valid;
	yrgb_pkg::quad_entry_t head_entry;

	yrgb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_ready   (push_ready),
		.push      (push),
		.push_entry(push_entry)
	);

	yrgb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	yrgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ dv/yuv420_to_rgb565_flip_rotate_top_tb.sv @@
module yuv420_to_rgb565_flip_rotate_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int RANDOM_QUADS  = 270;
	localparam int HOLD_CYCLES   = 64;
	localparam int SHOWN_ERRORS  = 10;

	// Fields from the lowest bit up: tl, tr, bl, br, u, v.
	typedef struct packed {
		logic signed [yrgb_pkg::PIX_W-1:0] v;
		logic signed [yrgb_pkg::PIX_W-1:0] u;
		logic signed [yrgb_pkg::PIX_W-1:0] br;
		logic signed [yrgb_pkg::PIX_W-1:0] bl;
		logic signed [yrgb_pkg::PIX_W-1:0] tr;
		logic signed [yrgb_pkg::PIX_W-1:0] tl;
	} quad_t;

	typedef struct packed {
		logic [yrgb_pkg::ADDR_W-1:0] addr;
		logic [yrgb_pkg::RGB_W-1:0]  rgb;
		logic                        last_q;
		logic                        done;
	} pixel_t;

	typedef struct {
		bit                          is_cfg;
		logic [yrgb_pkg::SIZE_W-1:0] w;
		logic [yrgb_pkg::SIZE_W-1:0] h;
		logic                        rot;
		quad_t                       q;
		bit                          typed;
		logic [yrgb_pkg::RGB_W-1:0]  rgb;
	} step_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [yrgb_pkg::IN_DATA_W-1:0]    s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [yrgb_pkg::OUT_DATA_W-1:0]   m_tdata;
	logic                              m_tuser;
	logic                              m_tlast;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [yrgb_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [yrgb_pkg::SIZE_W-1:0]       cfg_data;

	yuv420_to_rgb565_flip_rotate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the block's registers and quad counters.
	logic [yrgb_pkg::SIZE_W-1:0] frame_w;
	logic [yrgb_pkg::SIZE_W-1:0] frame_h;
	logic                        rot_mode;
	int                          quad_col;
	int                          quad_row;

	pixel_t pending_pixels [$];
	int     mismatches;
	int     src_idle_pct;
	int     sink_idle_pct;
	bit     hold_req;
	bit     rx_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("yuv420_to_rgb565_flip_rotate_top_tb NOT OK");
		$finish;
	end

	function automatic int clip(int x, int hi);
		if (x < 0)
			return 0;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic int frame_dim(logic [yrgb_pkg::SIZE_W-1:0] v, int maxv);
		int d;
		d = int'(v) & ~1;
		if (d < 2)
			d = 2;
		if (d > maxv)
			d = maxv & ~1;
		return d;
	endfunction

	function automatic logic [yrgb_pkg::RGB_W-1:0] rgb565(int l, int cc, int cg, int ca);
		int half;
		half = l >>> 1;
		return {5'(clip(half + ca, 31)), 6'(clip(l + cg, 63)), 5'(clip(half + cc, 31))};
	endfunction

	// Works out the four pixels of one quad and advances the quad counters.
	function automatic void convert_quad(quad_t q);
		int                          w, h, u, v, cc, cg, ca;
		bit                          end_col, end_row;
		logic [yrgb_pkg::ADDR_W-1:0] base;
		logic [yrgb_pkg::ADDR_W-1:0] addr [4];
		int                          luma [4];
		pixel_t                      px;
		w = frame_dim(frame_w, yrgb_pkg::DEF_MAX_WIDTH);
		h = frame_dim(frame_h, yrgb_pkg::DEF_MAX_HEIGHT);
		u = int'($signed(q.u));
		v = int'($signed(q.v));
		luma = '{int'($signed(q.tl)), int'($signed(q.tr)),
			int'($signed(q.bl)), int'($signed(q.br))};
		cc = (2 * u + (u >>> 5) - 64) >>> 1;
		cg = 31 - (u >>> 2) - (u >>> 3) - (v >>> 1) - (v >>> 4);
		ca = (v + (v >>> 3) - 36) >>> 1;
		end_col = (quad_col + 2) >= w;
		end_row = (quad_row + 2) >= h;
		if (rot_mode) begin
			base = yrgb_pkg::ADDR_W'(quad_row + quad_col * h);
			addr = '{base, yrgb_pkg::ADDR_W'(base + h), yrgb_pkg::ADDR_W'(base + 1),
				yrgb_pkg::ADDR_W'(base + h + 1)};
		end else begin
			// A row left past a shrunken height goes negative and wraps.
			base = yrgb_pkg::ADDR_W'((h - 1 - quad_row) * w + quad_col);
			addr = '{base, yrgb_pkg::ADDR_W'(base + 1), yrgb_pkg::ADDR_W'(base - w),
				yrgb_pkg::ADDR_W'(base - w + 1)};
		end
		for (int k = 0; k < 4; k++) begin
			px.addr   = addr[k];
			px.rgb    = rgb565(luma[k], cc, cg, ca);
			px.last_q = (k == 3);
			px.done   = (k == 3) && end_col && end_row;
			pending_pixels.push_back(px);
		end
		if (end_col) begin
			quad_col = 0;
			quad_row = end_row ? 0 : quad_row + 2;
		end else begin
			quad_col += 2;
		end
	endfunction

	function automatic step_t cfg_row(int w, int h, int rot);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.w = yrgb_pkg::SIZE_W'(w);
		s.h = yrgb_pkg::SIZE_W'(h);
		s.rot = rot[0];
		return s;
	endfunction

	function automatic step_t quad_step(int tl, int tr, int bl, int br, int u, int v);
		step_t s;
		s = '{default: '0};
		s.q = {8'(v), 8'(u), 8'(br), 8'(bl), 8'(tr), 8'(tl)};
		return s;
	endfunction

	// Uniform luma, so all four pixels carry the same colour.
	function automatic step_t checked_row(int l, int u, int v,
			logic [yrgb_pkg::RGB_W-1:0] rgb);
		step_t s;
		s = quad_step(l, l, l, l, u, v);
		s.typed = 1'b1;
		s.rgb = rgb;
		return s;
	endfunction

	function automatic quad_t random_quad();
		logic [yrgb_pkg::IN_DATA_W-1:0] raw;
		for (int k = 0; k < 6; k++)
			case ($urandom_range(7))
				0: raw[8*k +: 8] = 8'h80;
				1: raw[8*k +: 8] = 8'h7F;
				default: raw[8*k +: 8] = 8'($urandom);
			endcase
		return quad_t'(raw);
	endfunction

	function automatic logic [yrgb_pkg::SIZE_W-1:0] pick_dim();
		case ($urandom_range(11))
			0: return yrgb_pkg::SIZE_W'($urandom);
			1: return yrgb_pkg::SIZE_W'($urandom_range(1));
			2: return {yrgb_pkg::SIZE_W{1'b1}};
			3: return yrgb_pkg::SIZE_W'($urandom_range(12, 2));
			default: return yrgb_pkg::SIZE_W'(2 * $urandom_range(6, 1));
		endcase
	endfunction

	task automatic configure(input logic [yrgb_pkg::SIZE_W-1:0] w,
			input logic [yrgb_pkg::SIZE_W-1:0] h, input logic rot);
		yrgb_pkg::cfg_reg_t          idx [3];
		logic [yrgb_pkg::SIZE_W-1:0] val [3];
		idx = '{yrgb_pkg::REG_FRAME_WIDTH, yrgb_pkg::REG_FRAME_HEIGHT,
			yrgb_pkg::REG_ROTATE_MODE};
		val = '{w, h, {{(yrgb_pkg::SIZE_W-1){1'b0}}, rot}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			case (idx[i])
				yrgb_pkg::REG_FRAME_WIDTH:  frame_w = val[i];
				yrgb_pkg::REG_FRAME_HEIGHT: frame_h = val[i];
				yrgb_pkg::REG_ROTATE_MODE:  rot_mode = val[i][0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_quad(input quad_t q, input bit typed,
			input logic [yrgb_pkg::RGB_W-1:0] rgb);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= yrgb_pkg::IN_DATA_W'({$urandom, $urandom});
			do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= q;
		do @(posedge clk); while (s_tready !== 1'b1);
		convert_quad(q);
		if (typed)
			for (int k = 1; k <= 4; k++)
				pending_pixels[pending_pixels.size() - k].rgb = rgb;
		@(negedge clk);
	endtask

	// Lets every expected pixel out, then gives the pipeline time to settle.
	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The long receiver hold-off runs here so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : pixel_check
		pixel_t got;
		pixel_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.addr   = m_tdata[yrgb_pkg::ADDR_W-1:0];
			got.rgb    = m_tdata[yrgb_pkg::ADDR_W +: yrgb_pkg::RGB_W];
			got.last_q = m_tuser;
			got.done   = m_tlast;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("%0t: unexpected pixel addr=%h rgb=%h last=%b done=%b",
						$time, got.addr, got.rgb, got.last_q, got.done);
			end else begin
				want = pending_pixels.pop_front();
				if (got.addr !== want.addr || got.rgb !== want.rgb ||
						got.last_q !== want.last_q || got.done !== want.done) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("%0t: expected %h %h %b %b, got %h %h %b %b",
							$time, want.addr, want.rgb, want.last_q, want.done,
							got.addr, got.rgb, got.last_q, got.done);
				end
			end
		end
	end

	initial begin
		step_t plan [$];
		int    quads_sent;
		int    burst;
		bit    pressure_done;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = yrgb_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		hold_req = 1'b0;
		rx_hold = 1'b0;
		mismatches = 0;
		quads_sent = 0;
		pressure_done = 1'b0;
		src_idle_pct = 21;
		sink_idle_pct = 77;
		frame_w = yrgb_pkg::RESET_WIDTH;
		frame_h = yrgb_pkg::RESET_HEIGHT;
		rot_mode = 1'b0;
		quad_col = 0;
		quad_row = 0;

		plan = '{
			checked_row(-128, -128, -128, 16'h02E0),
			checked_row(127, 127, 127, 16'hFD5F),
			checked_row(-128, 127, 127, 16'h001F),
			checked_row(127, -128, -128, 16'h07E0),
			quad_step(0, 0, 0, 0, 32, 32),
			quad_step(-128, 127, 0, -1, 32, 32),
			// Shrinking to 2x2 leaves the column past the width for one quad.
			cfg_row(2, 2, 0),
			quad_step(1, -1, 64, -64, -1, 0),
			quad_step(85, -86, 42, -43, 85, -86),
			cfg_row(2, 2, 1),
			quad_step(-1, -2, 3, 100, -100, 64),
			// Odd sizes lose their low bit.
			cfg_row(5, 3, 0),
			quad_step(16, -16, 32, -32, 0, -1),
			quad_step(50, 60, 70, 80, -50, 30),
			// Sizes below two count as two.
			cfg_row(0, 1, 1),
			quad_step(-90, 90, -45, 45, 127, -128),
			// Oversized frames saturate at the maximum.
			cfg_row(4095, 4094, 0),
			quad_step(10, 20, 30, 40, 32, 32),
			quad_step(-10, -20, -30, -40, -32, -32),
			cfg_row(4, 2, 1),
			quad_step(127, -128, 127, -128, 16, 48),
			cfg_row(4, 4, 0),
			quad_step(7, 8, 9, 10, 11, 12),
			quad_step(3, -3, 5, -5, 40, 24),
			// The row counter now lies past the height, so addresses wrap.
			cfg_row(2, 2, 0),
			quad_step(-7, -8, -9, -10, -11, -12)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_pixels();
				configure(plan[i].w, plan[i].h, plan[i].rot);
			end else begin
				send_quad(plan[i].q, plan[i].typed, plan[i].rgb);
			end
		end

		while (quads_sent < RANDOM_QUADS) begin
			drain_pixels();
			if (quads_sent < RANDOM_QUADS / 3) begin
				src_idle_pct = 21;
				sink_idle_pct = 77;
			end else if (quads_sent < 2 * RANDOM_QUADS / 3) begin
				src_idle_pct = 77;
				sink_idle_pct = 21;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			configure(pick_dim(), pick_dim(), 1'($urandom));
			burst = $urandom_range(30, 8);
			if (quads_sent >= 2 * RANDOM_QUADS / 3 && !pressure_done) begin
				pressure_done = 1'b1;
				hold_req = 1'b1;
				burst = 30;
			end
			if (burst > RANDOM_QUADS - quads_sent)
				burst = RANDOM_QUADS - quads_sent;
			repeat (burst) begin
				send_quad(random_quad(), 1'b0, '0);
				quads_sent++;
			end
		end

		drain_pixels();
		if (mismatches == 0)
			$display("yuv420_to_rgb565_flip_rotate_top_tb OK");
		else
			$display("yuv420_to_rgb565_flip_rotate_top_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/yrgb_pkg.sv
rtl/core/yrgb_front.sv
rtl/core/yrgb_queue.sv
rtl/core/yrgb_back.sv
rtl/core/yuv420_to_rgb565_flip_rotate_top.sv
dv/yuv420_to_rgb565_flip_rotate_top_tb.sv
